@@ rtl/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared constants, types and reset values for the vertex transform unit.
// ----------------------------------------------------------------------------
`default_nettype none
package vtpd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int MAG_W         = PROD_W;
    localparam int ADDR_W        = 6;
    localparam int REG_W         = 64;
    localparam int DIV_STAGES    = COORD_W;

    localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] NEG_MAX = 32'h8000_0000;

    typedef enum logic [2:0]
    {
        REG_ROW0_COEF01 = 3'd0,
        REG_ROW0_COEF23 = 3'd1,
        REG_ROW1_COEF01 = 3'd2,
        REG_ROW1_COEF23 = 3'd3,
        REG_ROW2_COEF01 = 3'd4,
        REG_ROW2_COEF23 = 3'd5,
        REG_ROW3_COEF01 = 3'd6,
        REG_ROW3_COEF23 = 3'd7
    } reg_idx_t;

    typedef struct packed
    {
        logic [2:0] neg;
        logic [2:0] ovf;
        logic       w_zero;
        logic       last;
    } side_t;

    function automatic logic [REG_W-1:0] coef_reset(input reg_idx_t idx, input int frac);
        logic [REG_W-1:0] one;
        logic [REG_W-1:0] r;
        one = REG_W'(1) << frac;
        case (idx)
            REG_ROW0_COEF01: r = one;
            REG_ROW1_COEF01: r = one << 32;
            REG_ROW2_COEF23: r = one;
            REG_ROW3_COEF23: r = one << 32;
            default:         r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/vtpd_div.sv @@
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`default_nettype none
module vtpd_div
(
    input  wire logic                       clk,
    input  wire logic                       ce,
    input  wire logic [vtpd_pkg::MAG_W-1:0]   num_hi,
    input  wire logic [vtpd_pkg::COORD_W-1:0] num_lo,
    input  wire logic [vtpd_pkg::MAG_W-1:0]   den,
    output      logic [vtpd_pkg::COORD_W-1:0] quo
);
    import vtpd_pkg::*;

    logic [MAG_W-1:0]   rem_reg [DIV_STAGES];
    logic [COORD_W-1:0] lo_reg  [DIV_STAGES];
    logic [COORD_W-1:0] q_reg   [DIV_STAGES];
    logic [MAG_W-1:0]   den_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_step
            logic [MAG_W-1:0]   rem_in;
            logic [COORD_W-1:0] lo_in;
            logic [COORD_W-1:0] q_in;
            logic [MAG_W-1:0]   den_in;
            logic [MAG_W:0]     trial;
            logic               take;

            if (k == 0)
            begin : g_first
                assign rem_in = num_hi;
                assign lo_in  = num_lo;
                assign q_in   = '0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign lo_in  = lo_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial = {rem_in, lo_in[COORD_W-1]};
            assign take  = trial >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k] <= take ? MAG_W'(trial - {1'b0, den_in}) : trial[MAG_W-1:0];
                    lo_reg[k]  <= {lo_in[COORD_W-2:0], 1'b0};
                    q_reg[k]   <= {q_in[COORD_W-2:0], take};
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/vertex_transform_perspective_divide_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit
// 4x4 homogeneous vertex transform followed by divide by w, Q format.
// ----------------------------------------------------------------------------
// The pipeline moves as a whole, taking one vertex per cycle, whenever the
// output register is empty or being taken. Each vertex passes through one
// multiply stage, one row-sum stage, two stages forming the magnitudes and the
// overflow test, 32 divider stages (one quotient bit each, three dividers side
// by side) and one saturation stage. The user must write matrix registers over
// the APB port only while the pipeline is empty; the block does not enforce it.
`default_nettype none
module vertex_transform_perspective_divide_unit
#(
    parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vtpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [vtpd_pkg::REG_W-1:0]  pwdata,
    output      logic [vtpd_pkg::REG_W-1:0]  prdata,
    output      logic                        pready,
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    input  wire logic [95:0]                 s_tdata,   // pos_x, pos_y, pos_z
    input  wire logic                        s_tlast,
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    output      logic [95:0]                 m_tdata,   // out_x, out_y, out_z
    output      logic                        m_tuser,   // w_zero
    output      logic                        m_tlast
);
    import vtpd_pkg::*;

    logic [REG_W-1:0] coef_reg [NUM_REGS];
    logic             wr_en;
    reg_idx_t         wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign prdata = coef_reg[paddr[ADDR_W-1:3]];

    genvar r, c;
    generate
        for (r = 0; r < NUM_REGS; r++)
        begin : g_reg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    coef_reg[r] <= coef_reset(reg_idx_t'(r), FRAC_BITS);
                else if (wr_en && wr_idx == reg_idx_t'(r))
                    coef_reg[r] <= pwdata;
            end
        end
    endgenerate

    logic ce;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DIV_STAGES-1:0] vd_reg;
    logic l1_reg, l2_reg, l3_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic signed [COORD_W-1:0] pos [3];
    assign pos[0] = s_tdata[31:0];
    assign pos[1] = s_tdata[63:32];
    assign pos[2] = s_tdata[95:64];

    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic signed [SUM_W-1:0]  sum_reg  [4];
    logic [MAG_W-1:0]         mag_reg  [4];
    logic                     sgn_reg  [4];
    logic [MAG_W-1:0]         nhi_reg  [3];
    logic [COORD_W-1:0]       nlo_reg  [3];
    logic [MAG_W-1:0]         den_reg;
    side_t                    side4_reg;
    side_t                    side_reg [DIV_STAGES];
    logic [COORD_W-1:0]       quo      [3];

    generate
        for (r = 0; r < 4; r++)
        begin : g_row
            logic signed [COORD_W-1:0] k3;
            logic signed [SUM_W-1:0]   term3;
            assign k3    = coef_reg[2*r+1][63:32];
            assign term3 = SUM_W'(k3) <<< FRAC_BITS;

            for (c = 0; c < 3; c++)
            begin : g_col
                logic signed [COORD_W-1:0] k;
                assign k = (c % 2 == 1) ? coef_reg[2*r + c/2][63:32]
                                        : coef_reg[2*r + c/2][31:0];
                always_ff @(posedge clk)
                begin
                    if (ce)
                        prod_reg[r][c] <= k * pos[c];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                                + SUM_W'(prod_reg[r][2]) + term3;
                    mag_reg[r] <= sum_reg[r][SUM_W-1] ? MAG_W'(-sum_reg[r])
                                                      : MAG_W'(sum_reg[r]);
                    sgn_reg[r] <= sum_reg[r][SUM_W-1];
                end
            end
        end

        for (r = 0; r < 3; r++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    nhi_reg[r] <= mag_reg[r] >> (COORD_W - FRAC_BITS);
                    nlo_reg[r] <= mag_reg[r][COORD_W-1:0] << FRAC_BITS;
                end
            end

            vtpd_div u_div
            (
                .clk    (clk),
                .ce     (ce),
                .num_hi (nhi_reg[r]),
                .num_lo (nlo_reg[r]),
                .den    (den_reg),
                .quo    (quo[r])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            l1_reg           <= s_tlast;
            l2_reg           <= l1_reg;
            l3_reg           <= l2_reg;
            den_reg          <= mag_reg[3];
            for (int i = 0; i < 3; i++)
            begin
                side4_reg.ovf[i] <= (mag_reg[i] >> (COORD_W - FRAC_BITS)) >= mag_reg[3];
                side4_reg.neg[i] <= sgn_reg[i] ^ sgn_reg[3];
            end
            side4_reg.w_zero <= mag_reg[3] == '0;
            side4_reg.last   <= l3_reg;
            side_reg[0]      <= side4_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vd_reg   <= '0;
            m_tvalid <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg   <= s_tvalid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            vd_reg   <= {vd_reg[DIV_STAGES-2:0], v4_reg};
            m_tvalid <= vd_reg[DIV_STAGES-1];
        end
    end

    side_t fin;
    assign fin = side_reg[DIV_STAGES-1];

    logic [COORD_W-1:0] res_next [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fin.w_zero)
                res_next[i] = '0;
            else if (fin.neg[i])
                res_next[i] = (fin.ovf[i] || quo[i][COORD_W-1]) ? NEG_MAX : COORD_W'(-quo[i]);
            else
                res_next[i] = (fin.ovf[i] || quo[i][COORD_W-1]) ? POS_MAX : quo[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m_tdata <= {res_next[2], res_next[1], res_next[0]};
            m_tuser <= fin.w_zero;
            m_tlast <= fin.last;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vtpd_checker.sv @@
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks for the vertex transform unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module vtpd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tuser
);
    a_zero_w_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("w_zero result carries nonzero data");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output free");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind vertex_transform_perspective_divide_unit vtpd_checker u_vtpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/sv/vertex_transform_perspective_divide_unit_tb.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit_tb
// Streams vertices through the transform unit under several matrices and
// checks every result against a predictor of the transform, the divide by w
// and the saturation, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_transform_perspective_divide_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vtpd_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed
    {
        logic        last;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } vertex_t;

    typedef struct packed
    {
        logic        last;
        logic        wz;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } proj_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
    logic [REG_W-1:0]  prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [95:0]       s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [95:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    vertex_t     pending_vertices[$];
    proj_t       expected_proj[$];
    logic [63:0] matrix_regs[NUM_REGS];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          quiet_mode;
    bit          driver_hold;
    int          src_gap;
    int          sink_gap;
    int          sink_hold;
    bit          sink_hold_req;

    vertex_transform_perspective_divide_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [127:0] row_dot(input int row, input vertex_t v);
        logic signed [127:0] acc;
        logic signed [31:0]  c0;
        logic signed [31:0]  c1;
        logic signed [31:0]  c2;
        logic signed [31:0]  c3;
        c0 = matrix_regs[2*row][31:0];
        c1 = matrix_regs[2*row][63:32];
        c2 = matrix_regs[2*row+1][31:0];
        c3 = matrix_regs[2*row+1][63:32];
        acc = 128'(c0) * 128'($signed(v.x)) + 128'(c1) * 128'($signed(v.y))
            + 128'(c2) * 128'($signed(v.z)) + (128'(c3) <<< FB);
        return acc;
    endfunction

    function automatic logic [31:0] divide_sat(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        bit           neg;
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        q = (nm << FB) / dm;
        if (neg)
            return (q >= 128'h8000_0000) ? NEG_MAX : 32'(-q);
        return (q > 128'h7FFF_FFFF) ? POS_MAX : q[31:0];
    endfunction

    function automatic proj_t project_vertex(input vertex_t v);
        proj_t               p;
        logic signed [127:0] w;
        w = row_dot(3, v);
        p.last = v.last;
        p.wz = (w == 0);
        if (p.wz)
        begin
            p.x = '0;
            p.y = '0;
            p.z = '0;
        end
        else
        begin
            p.x = divide_sat(row_dot(0, v), w);
            p.y = divide_sat(row_dot(1, v), w);
            p.z = divide_sat(row_dot(2, v), w);
        end
        return p;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return NEG_MAX;
            2: return 32'(0);
            3, 4: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return NEG_MAX;
            2: return 32'(0);
            3: return 32'(1 << FB);
            4, 5: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        pending_vertices.push_back(v);
    endtask

    task automatic drain_pipeline();
        while (pending_vertices.size() != 0 || expected_proj.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_matrix_reg(input reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        matrix_regs[idx] = value;
        @(posedge clk);
    endtask

    task automatic load_matrix(input int kind);
        logic [63:0] m[NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (kind)
                0: m[i] = coef_reset(reg_idx_t'(i), FB);
                1: m[i] = {rand_coef(), rand_coef()};
                2: m[i] = (i % 2 == 0) ? {NEG_MAX, POS_MAX} : {POS_MAX, NEG_MAX};
                3: m[i] = '1;
                default: m[i] = (i == 7) ? {32'(1 << FB), 32'($urandom_range(0, 3) << FB)}
                                         : {rand_coef(), rand_coef()};
            endcase
        end
        for (int i = 0; i < NUM_REGS; i++)
            write_matrix_reg(reg_idx_t'(i), m[i]);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap > 0)
            begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_vertices.size() != 0 && !driver_hold)
            begin
                vertex_t v;
                v = pending_vertices.pop_front();
                expected_proj.push_back(project_vertex(v));
                s_tvalid <= 1'b1;
                s_tdata  <= {v.z, v.y, v.x};
                s_tlast  <= v.last;
                if (!quiet_mode && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 5);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_gap  <= 0;
            sink_hold <= 0;
        end
        else if (sink_hold_req && sink_hold == 0)
        begin
            sink_hold <= 300;
            m_tready  <= 1'b0;
        end
        else if (sink_hold > 1)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet_mode && $urandom_range(0, 7) == 0)
        begin
            sink_gap <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            proj_t exp_p;
            proj_t got;
            got = {m_tlast, m_tuser, m_tdata};
            if (expected_proj.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_p = expected_proj.pop_front();
                if (got !== exp_p)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("mismatch: expected x=%h y=%h z=%h wz=%b last=%b",
                                 exp_p.x, exp_p.y, exp_p.z, exp_p.wz, exp_p.last);
                        $display("          actual   x=%h y=%h z=%h wz=%b last=%b",
                                 got.x, got.y, got.z, got.wz, got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else if (pending_vertices.size() != 0 || expected_proj.size() != 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out <= 1'b1;
        end
    end

    always @(posedge timed_out)
    begin
        $display("** vertex_transform_perspective_divide_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        quiet_mode = 1'b0;
        driver_hold = 1'b0;
        sink_hold_req = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            matrix_regs[i] = coef_reset(reg_idx_t'(i), FB);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset: extremes, zero vertex, batch end
        add_vertex(POS_MAX, NEG_MAX, 32'(1 << FB), 1'b0);
        add_vertex(NEG_MAX, POS_MAX, NEG_MAX, 1'b1);
        add_vertex('0, '0, '0, 1'b0);
        add_vertex('1, 32'(1), 32'h0001_8000, 1'b1);
        drain_pipeline();

        load_matrix(4);
        for (int i = 0; i < 6; i++)
            add_vertex(rand_coord(), rand_coord(), rand_coord(), i[0]);
        drain_pipeline();

        // w from the z row so zero z gives zero w
        write_matrix_reg(REG_ROW3_COEF01, '0);
        write_matrix_reg(REG_ROW3_COEF23, {32'(0), 32'(1 << FB)});
        add_vertex(32'(5 << FB), 32'(3 << FB), '0, 1'b1);
        add_vertex(POS_MAX, POS_MAX, 32'(1), 1'b0);
        add_vertex(NEG_MAX, POS_MAX, 32'h8000_0001, 1'b0);
        add_vertex(32'(1), 32'(1), NEG_MAX, 1'b1);
        drain_pipeline();

        load_matrix(2);
        add_vertex(POS_MAX, POS_MAX, POS_MAX, 1'b0);
        add_vertex(NEG_MAX, NEG_MAX, NEG_MAX, 1'b1);
        add_vertex(32'(1), '0, '1, 1'b0);
        drain_pipeline();

        load_matrix(3);
        add_vertex(POS_MAX, NEG_MAX, '0, 1'b1);
        add_vertex(32'(1 << FB), '1, 32'(7), 1'b0);
        drain_pipeline();

        for (int phase = 0; phase < 10; phase++)
        begin
            int n;
            load_matrix((phase % 3 == 0) ? 4 : ((phase == 5) ? 0 : 1));
            n = 190;
            if (phase == 9)
                quiet_mode = 1'b1;
            for (int i = 0; i < n; i++)
                add_vertex(rand_coord(), rand_coord(), rand_coord(), ($urandom_range(0, 5) == 0));
            if (phase == 2)
            begin
                sink_hold_req = 1'b1;
                wait (sink_hold != 0);
                sink_hold_req = 1'b0;
            end
            if (phase == 4)
            begin
                repeat (40) @(posedge clk);
                driver_hold = 1'b1;
                while (expected_proj.size() != 0)
                    @(posedge clk);
                driver_hold = 1'b0;
            end
            drain_pipeline();
        end

        if (mismatches == 0 && expected_proj.size() == 0)
            $display("** vertex_transform_perspective_divide_unit: PASSED **");
        else
            $display("** vertex_transform_perspective_divide_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/vtpd_pkg.sv
rtl/vtpd_div.sv
rtl/vertex_transform_perspective_divide_unit.sv
rtl/vtpd_checker.sv
tb/sv/vertex_transform_perspective_divide_unit_tb.sv
